// ----- rtl/lms_pkg.sv -----
package lms_pkg;

  localparam int NUM_COMPONENTS_DEF = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 58;
  localparam int SETUP_W    = 58;
  localparam int WEIGHTS_W  = 48;
  localparam int TH_W       = 16;

  localparam logic [2:0] REG_SEED    = 3'd0;
  localparam logic [2:0] REG_WEIGHTS = 3'd1;
  localparam logic [2:0] REG_COMP0   = 3'd2;

  localparam logic [1:0] KIND_CONST     = 2'd0;
  localparam logic [1:0] KIND_NORMAL    = 2'd1;
  localparam logic [1:0] KIND_LOGNORMAL = 2'd2;
  localparam logic [1:0] KIND_CONST_ALT = 2'd3;

  localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] LOG2E_Q30   = 32'd1549082005;
  localparam logic [31:0] LN2_Q30     = 32'd744261118;
  localparam logic [31:0] TWO_LN2_Q31 = 32'd2977044472;

  localparam logic [31:0] SAMPLE_MAX = 32'h7FFF_FFFF;

  // exp argument limits in Q.20
  localparam logic signed [33:0] EXP_HI_LIM = 34'sd11534336;
  localparam logic signed [33:0] EXP_LO_LIM = -34'sd12582912;

  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

  // Taylor divisors for the sine (even quadrant) and cosine (odd quadrant)
  function automatic logic [7:0] sine_div(input logic [2:0] step, input logic odd);
    logic [7:0] d;
    unique case (step)
      3'd0: d = odd ? 8'd182 : 8'd210;
      3'd1: d = odd ? 8'd132 : 8'd156;
      3'd2: d = odd ? 8'd90  : 8'd110;
      3'd3: d = odd ? 8'd56  : 8'd72;
      3'd4: d = odd ? 8'd30  : 8'd42;
      3'd5: d = odd ? 8'd12  : 8'd20;
      3'd6: d = odd ? 8'd2   : 8'd6;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

  // floor(2^32 / d); the divisor of one takes all ones
  function automatic logic [31:0] recip32(input logic [7:0] d);
    logic [31:0] r;
    unique case (d)
      8'd2:   r = 32'd2147483648;
      8'd3:   r = 32'd1431655765;
      8'd4:   r = 32'd1073741824;
      8'd5:   r = 32'd858993459;
      8'd6:   r = 32'd715827882;
      8'd7:   r = 32'd613566756;
      8'd8:   r = 32'd536870912;
      8'd9:   r = 32'd477218588;
      8'd10:  r = 32'd429496729;
      8'd11:  r = 32'd390451572;
      8'd12:  r = 32'd357913941;
      8'd20:  r = 32'd214748364;
      8'd30:  r = 32'd143165576;
      8'd42:  r = 32'd102261126;
      8'd56:  r = 32'd76695844;
      8'd72:  r = 32'd59652323;
      8'd90:  r = 32'd47721858;
      8'd110: r = 32'd39045157;
      8'd132: r = 32'd32537631;
      8'd156: r = 32'd27531841;
      8'd182: r = 32'd23598721;
      8'd210: r = 32'd20452225;
      default: r = 32'hFFFF_FFFF;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/lms_mul.sv -----
module lms_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);

  logic [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= 64'(a) * 64'(b);
  end

  assign prod = prod_r;

endmodule

// ----- rtl/lms_root.sv -----
module lms_root (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [61:0] radicand,
  output logic        busy,
  output logic [30:0] root
);

  logic [61:0] rem_r, rem_nxt;
  logic [62:0] res_r, res_nxt;
  logic [62:0] bit_r, bit_nxt;
  logic [63:0] trial;

  assign trial = {1'b0, res_r} + {1'b0, bit_r};

  always_comb begin
    rem_nxt = rem_r;
    res_nxt = res_r;
    bit_nxt = bit_r;
    if (start) begin
      rem_nxt = radicand;
      res_nxt = '0;
      bit_nxt = 63'(1) << 62;
    end else if (bit_r != '0) begin
      if ({2'b0, rem_r} >= trial) begin
        rem_nxt = rem_r - trial[61:0];
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
    end else begin
      bit_r <= bit_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
  end

  assign busy = (bit_r != '0);
  assign root = res_r[30:0];

endmodule

// ----- rtl/lognormal_mixture_sampler_core.sv -----
// Mixture sampler: one request on the in_ channel returns one sample on the out_ channel.
// Input: in_valid/in_stall carry a tag; a transaction completes when valid is high and
// stall is low. Output: out_valid/out_stall carry sample (Q16.16), component,
// saturated and the echoed tag. Registers are written through cfg_we/cfg_index/cfg_data
// while no request is in flight, which the user ensures; the block does not enforce it.
// A seed write restarts the generator. Latency grows from a constant component to a
// normal one and on to a lognormal one (an exponential argument outside its range skips
// the exponential and finishes like a normal one). It varies with the leading-zero shift
// of the first draw and with the sine product, taken only in even quadrants. The single
// shared 32x32 multiplier registers its product and takes new operands while it is read;
// it does 32 squarings for the logarithm and three products per Taylor step (seven for
// the sine, twelve for the exponential); the 32-step bit-serial root has its own unit.
// One request is in flight at a time; in_stall is high from acceptance until the result
// moves into the output register, so a new request can be taken in the following cycle.
// That register lets the next request start while a result still waits on out_stall;
// a finished result waits internally only if the output register is full and out_stall is high.
// Reset clears the state, weights, setups and out_valid and loads the generator with 1.
module lognormal_mixture_sampler_core #(
  parameter int NUM_COMPONENTS = lms_pkg::NUM_COMPONENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_tag,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_sample,
  output logic [1:0]                    out_component,
  output logic                          out_saturated,
  output logic [7:0]                    out_tag_out,
  input  logic                          cfg_we,
  input  logic [lms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lms_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int KW = $clog2(NUM_COMPONENTS);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DRAW1 = 5'd1;
  localparam logic [4:0] S_DRAW2 = 5'd2;
  localparam logic [4:0] S_NORM  = 5'd3;
  localparam logic [4:0] S_LSQ   = 5'd4;
  localparam logic [4:0] S_LSQU  = 5'd5;
  localparam logic [4:0] S_LNH   = 5'd6;
  localparam logic [4:0] S_LNL   = 5'd7;
  localparam logic [4:0] S_LNC   = 5'd8;
  localparam logic [4:0] S_ROOT  = 5'd9;
  localparam logic [4:0] S_SIN0  = 5'd10;
  localparam logic [4:0] S_SIN1  = 5'd11;
  localparam logic [4:0] S_SIN2  = 5'd12;
  localparam logic [4:0] S_TM    = 5'd13;
  localparam logic [4:0] S_TR    = 5'd14;
  localparam logic [4:0] S_TQ    = 5'd15;
  localparam logic [4:0] S_TC    = 5'd16;
  localparam logic [4:0] S_SMAG  = 5'd17;
  localparam logic [4:0] S_SMAGU = 5'd18;
  localparam logic [4:0] S_Z     = 5'd19;
  localparam logic [4:0] S_ZU    = 5'd20;
  localparam logic [4:0] S_D     = 5'd21;
  localparam logic [4:0] S_E0    = 5'd22;
  localparam logic [4:0] S_E1    = 5'd23;
  localparam logic [4:0] S_E2    = 5'd24;
  localparam logic [4:0] S_E3    = 5'd25;
  localparam logic [4:0] S_E4    = 5'd26;
  localparam logic [4:0] S_DONE  = 5'd27;

  logic [4:0]  state_r, state_nxt;
  logic [31:0] rng_r, rng_nxt;
  logic [lms_pkg::WEIGHTS_W-1:0] weights_r, weights_nxt;
  logic [lms_pkg::SETUP_W-1:0]   setup_r [NUM_COMPONENTS];

  logic [1:0]         kind_r, kind_nxt;
  logic signed [27:0] mean_r, mean_nxt;
  logic [27:0]        sigma_r, sigma_nxt;
  logic [KW-1:0]      comp_r, comp_nxt;
  logic [7:0]         tag_r, tag_nxt;
  logic [31:0]        m_r, m_nxt;
  logic [4:0]         lz_r, lz_nxt;
  logic [31:0]        f_r, f_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic [31:0]        p2_r, p2_nxt;
  logic [53:0]        hi_r, hi_nxt;
  logic [30:0]        root_r, root_nxt;
  logic [30:0]        th_r, th_nxt;
  logic [31:0]        coef_r, coef_nxt;
  logic [31:0]        t_r, t_nxt;
  logic [3:0]         step_r, step_nxt;
  logic               exp_mode_r, exp_mode_nxt;
  logic [31:0]        v_r, v_nxt;
  logic [31:0]        q0_r, q0_nxt;
  logic [30:0]        mag_r, mag_nxt;
  logic               yneg_r, yneg_nxt;
  logic [23:0]        ymag_r, ymag_nxt;
  logic signed [5:0]  n_r, n_nxt;
  logic [31:0]        res_r, res_nxt;
  logic               sat_r, sat_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_sample_r, out_sample_nxt;
  logic [1:0]         out_comp_r, out_comp_nxt;
  logic               out_sat_r, out_sat_nxt;
  logic [7:0]         out_tag_r, out_tag_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        root_start;
  logic        root_busy;
  logic [30:0] root_res;
  logic [61:0] root_rad;

  logic [31:0]        x_draw;
  logic [KW-1:0]      sel;
  logic [lms_pkg::SETUP_W-1:0] sel_setup;
  logic [37:0]        nl2;
  logic [54:0]        ln_sum;
  logic [7:0]         div_d;
  logic [31:0]        rem_c;
  logic [31:0]        qq;
  logic signed [33:0] y_c;
  logic signed [33:0] y_abs;
  logic [63:0]        w_c;
  logic signed [6:0]  nd;
  logic [6:0]         shr;
  logic [32:0]        r_c;
  logic               in_acc;

  lms_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_p)
  );

  lms_root u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (root_rad),
    .busy     (root_busy),
    .root     (root_res)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign x_draw   = lms_pkg::xorshift32(rng_r);

  always_comb begin
    sel = KW'(NUM_COMPONENTS - 1);
    for (int i = NUM_COMPONENTS - 2; i >= 0; i--) begin
      if (x_draw[31:16] < weights_r[lms_pkg::TH_W*i +: lms_pkg::TH_W]) begin
        sel = KW'(i);
      end
    end
  end

  assign sel_setup = setup_r[sel];

  assign nl2      = {(6'(lz_r) + 6'd1), 32'd0} - {6'd0, f_r};
  assign ln_sum   = {1'b0, hi_r} + 55'(mul_p[47:16]);
  assign root_rad = {ln_sum[52:15], 24'd0};
  assign div_d    = exp_mode_r ? {4'd0, step_r} : lms_pkg::sine_div(step_r[2:0], p2_r[30]);
  assign rem_c    = v_r - mul_p[31:0];
  assign qq       = (rem_c >= 32'(div_d)) ? q0_r + 32'd1 : q0_r;
  assign y_c      = p2_r[31] ? 34'(mean_r) - $signed({3'b0, mul_p[58:28]})
                             : 34'(mean_r) + $signed({3'b0, mul_p[58:28]});
  assign y_abs    = y_c[33] ? -y_c : y_c;
  assign w_c      = yneg_r ? 64'd0 - mul_p : mul_p;
  assign nd       = 7'(n_r) - 7'sd14;
  assign shr      = 7'(-nd);
  assign r_c      = nd[6] ? ({1'b0, t_r} >> shr) : ({1'b0, t_r} << nd[5:0]);

  always_comb begin
    state_nxt    = state_r;
    rng_nxt      = rng_r;
    weights_nxt  = weights_r;
    kind_nxt     = kind_r;
    mean_nxt     = mean_r;
    sigma_nxt    = sigma_r;
    comp_nxt     = comp_r;
    tag_nxt      = tag_r;
    m_nxt        = m_r;
    lz_nxt       = lz_r;
    f_nxt        = f_r;
    cnt_nxt      = cnt_r;
    p2_nxt       = p2_r;
    hi_nxt       = hi_r;
    root_nxt     = root_r;
    th_nxt       = th_r;
    coef_nxt     = coef_r;
    t_nxt        = t_r;
    step_nxt     = step_r;
    exp_mode_nxt = exp_mode_r;
    v_nxt        = v_r;
    q0_nxt       = q0_r;
    mag_nxt      = mag_r;
    yneg_nxt     = yneg_r;
    ymag_nxt     = ymag_r;
    n_nxt        = n_r;
    res_nxt      = res_r;
    sat_nxt      = sat_r;
    out_sample_nxt = out_sample_r;
    out_comp_nxt   = out_comp_r;
    out_sat_nxt    = out_sat_r;
    out_tag_nxt    = out_tag_r;
    out_valid_nxt  = out_valid_r && out_stall;
    mul_a      = '0;
    mul_b      = '0;
    root_start = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          rng_nxt   = x_draw;
          tag_nxt   = in_tag;
          comp_nxt  = sel;
          kind_nxt  = sel_setup[1:0];
          mean_nxt  = $signed(sel_setup[29:2]);
          sigma_nxt = sel_setup[57:30];
          sat_nxt   = 1'b0;
          res_nxt   = 32'($signed(sel_setup[29:2]) >>> 4);
          if (sel_setup[1:0] == lms_pkg::KIND_NORMAL ||
              sel_setup[1:0] == lms_pkg::KIND_LOGNORMAL) begin
            state_nxt = S_DRAW1;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DRAW1: begin
        rng_nxt   = x_draw;
        m_nxt     = (x_draw == '0) ? 32'd1 : x_draw;
        lz_nxt    = '0;
        state_nxt = S_DRAW2;
      end
      S_DRAW2: begin
        rng_nxt   = x_draw;
        p2_nxt    = x_draw;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (m_r[31]) begin
          cnt_nxt   = '0;
          f_nxt     = '0;
          state_nxt = S_LSQ;
        end else begin
          m_nxt  = m_r << 1;
          lz_nxt = lz_r + 5'd1;
        end
      end
      S_LSQ: begin
        mul_a     = m_r;
        mul_b     = m_r;
        state_nxt = S_LSQU;
      end
      S_LSQU: begin
        if (mul_p[63]) begin
          m_nxt = mul_p[63:32];
        end else begin
          m_nxt = mul_p[62:31];
        end
        f_nxt   = {f_r[30:0], mul_p[63]};
        cnt_nxt = cnt_r + 5'd1;
        state_nxt = (cnt_r == 5'd31) ? S_LNH : S_LSQ;
      end
      S_LNH: begin
        mul_a     = {10'd0, nl2[37:16]};
        mul_b     = lms_pkg::TWO_LN2_Q31;
        state_nxt = S_LNL;
      end
      S_LNL: begin
        hi_nxt    = mul_p[53:0];
        mul_a     = {16'd0, nl2[15:0]};
        mul_b     = lms_pkg::TWO_LN2_Q31;
        state_nxt = S_LNC;
      end
      S_LNC: begin
        root_start = 1'b1;
        state_nxt  = S_ROOT;
      end
      S_ROOT: begin
        if (!root_busy) begin
          root_nxt  = root_res;
          state_nxt = S_SIN0;
        end
      end
      S_SIN0: begin
        mul_a     = {2'd0, p2_r[29:0]};
        mul_b     = lms_pkg::HALF_PI_Q30;
        state_nxt = S_SIN1;
      end
      S_SIN1: begin
        th_nxt    = mul_p[60:30];
        mul_a     = {1'b0, mul_p[60:30]};
        mul_b     = {1'b0, mul_p[60:30]};
        state_nxt = S_SIN2;
      end
      S_SIN2: begin
        coef_nxt     = mul_p[61:30];
        t_nxt        = lms_pkg::ONE_Q30;
        step_nxt     = '0;
        exp_mode_nxt = 1'b0;
        state_nxt    = S_TM;
      end
      S_TM: begin
        mul_a     = coef_r;
        mul_b     = t_r;
        state_nxt = S_TR;
      end
      S_TR: begin
        v_nxt     = mul_p[61:30];
        mul_a     = mul_p[61:30];
        mul_b     = lms_pkg::recip32(div_d);
        state_nxt = S_TQ;
      end
      S_TQ: begin
        q0_nxt    = mul_p[63:32];
        mul_a     = mul_p[63:32];
        mul_b     = 32'(div_d);
        state_nxt = S_TC;
      end
      S_TC: begin
        if (exp_mode_r) begin
          t_nxt    = lms_pkg::ONE_Q30 + qq;
          step_nxt = step_r - 4'd1;
          state_nxt = (step_r == 4'd1) ? S_E4 : S_TM;
        end else begin
          t_nxt    = (qq > lms_pkg::ONE_Q30) ? 32'd0 : lms_pkg::ONE_Q30 - qq;
          step_nxt = step_r + 4'd1;
          if (step_r == 4'd6) begin
            if (p2_r[30]) begin
              mag_nxt   = t_nxt[30:0];
              state_nxt = S_Z;
            end else begin
              state_nxt = S_SMAG;
            end
          end else begin
            state_nxt = S_TM;
          end
        end
      end
      S_SMAG: begin
        mul_a     = {1'b0, th_r};
        mul_b     = t_r;
        state_nxt = S_SMAGU;
      end
      S_SMAGU: begin
        mag_nxt   = mul_p[60:30];
        state_nxt = S_Z;
      end
      S_Z: begin
        mul_a     = {1'b0, root_r};
        mul_b     = {1'b0, mag_r};
        state_nxt = S_ZU;
      end
      S_ZU: begin
        mul_a     = {4'd0, sigma_r};
        mul_b     = {1'b0, mul_p[60:30]};
        state_nxt = S_D;
      end
      S_D: begin
        if (kind_r == lms_pkg::KIND_NORMAL) begin
          res_nxt   = 32'(y_c >>> 4);
          state_nxt = S_DONE;
        end else if (y_c >= lms_pkg::EXP_HI_LIM) begin
          res_nxt   = lms_pkg::SAMPLE_MAX;
          sat_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else if (y_c <= lms_pkg::EXP_LO_LIM) begin
          res_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          yneg_nxt  = y_c[33];
          ymag_nxt  = y_abs[23:0];
          state_nxt = S_E0;
        end
      end
      S_E0: begin
        mul_a     = {8'd0, ymag_r};
        mul_b     = lms_pkg::LOG2E_Q30;
        state_nxt = S_E1;
      end
      S_E1: begin
        n_nxt     = $signed(w_c[55:50]);
        coef_nxt  = {2'd0, w_c[49:20]};
        state_nxt = S_E2;
      end
      S_E2: begin
        mul_a     = coef_r;
        mul_b     = lms_pkg::LN2_Q30;
        state_nxt = S_E3;
      end
      S_E3: begin
        coef_nxt     = {2'd0, mul_p[59:30]};
        t_nxt        = lms_pkg::ONE_Q30;
        step_nxt     = 4'd12;
        exp_mode_nxt = 1'b1;
        state_nxt    = S_TM;
      end
      S_E4: begin
        if (r_c[32:31] != 2'd0) begin
          res_nxt = lms_pkg::SAMPLE_MAX;
          sat_nxt = 1'b1;
        end else begin
          res_nxt = r_c[31:0];
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = res_r;
          out_comp_nxt   = 2'(comp_r);
          out_sat_nxt    = sat_r;
          out_tag_nxt    = tag_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      if (cfg_index == lms_pkg::REG_SEED) begin
        rng_nxt = (cfg_data[31:0] == '0) ? 32'd1 : cfg_data[31:0];
      end else if (cfg_index == lms_pkg::REG_WEIGHTS) begin
        weights_nxt = cfg_data[lms_pkg::WEIGHTS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rng_r       <= 32'd1;
      weights_r   <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < NUM_COMPONENTS; j++) begin
        setup_r[j] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      rng_r       <= rng_nxt;
      weights_r   <= weights_nxt;
      out_valid_r <= out_valid_nxt;
      for (int j = 0; j < NUM_COMPONENTS; j++) begin
        if (cfg_we && cfg_index == lms_pkg::CFG_IDX_W'(int'(lms_pkg::REG_COMP0) + j)) begin
          setup_r[j] <= cfg_data[lms_pkg::SETUP_W-1:0];
        end
      end
    end
    kind_r       <= kind_nxt;
    mean_r       <= mean_nxt;
    sigma_r      <= sigma_nxt;
    comp_r       <= comp_nxt;
    tag_r        <= tag_nxt;
    m_r          <= m_nxt;
    lz_r         <= lz_nxt;
    f_r          <= f_nxt;
    cnt_r        <= cnt_nxt;
    p2_r         <= p2_nxt;
    hi_r         <= hi_nxt;
    root_r       <= root_nxt;
    th_r         <= th_nxt;
    coef_r       <= coef_nxt;
    t_r          <= t_nxt;
    step_r       <= step_nxt;
    exp_mode_r   <= exp_mode_nxt;
    v_r          <= v_nxt;
    q0_r         <= q0_nxt;
    mag_r        <= mag_nxt;
    yneg_r       <= yneg_nxt;
    ymag_r       <= ymag_nxt;
    n_r          <= n_nxt;
    res_r        <= res_nxt;
    sat_r        <= sat_nxt;
    out_sample_r <= out_sample_nxt;
    out_comp_r   <= out_comp_nxt;
    out_sat_r    <= out_sat_nxt;
    out_tag_r    <= out_tag_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_sample    = $signed(out_sample_r);
  assign out_component = out_comp_r;
  assign out_saturated = out_sat_r;
  assign out_tag_out   = out_tag_r;

endmodule
